// ===== hw/rtl/sapa_pkg.sv =====
package sapa_pkg;

  // Default depth of the host number space.
  localparam int unsigned MAX_HOST_BITS = 8;

  // Configuration register indexes.
  localparam logic REG_NETWORK = 1'b0;
  localparam logic REG_PREFIX  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_IGNORED   = 2'd2;

  // Prefix length written after reset.
  localparam logic [4:0] PREFIX_RESET = 5'd24;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ROOT,
    S_DESC,
    S_LEAF,
    S_UP,
    S_DONE
  } walk_state_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
    logic [7:0]  free_count;
  } result_t;

  // Host width for a prefix length: 32 minus the prefix, clamped to 2..max_bits.
  function automatic logic [5:0] host_width(input logic [4:0] prefix,
                                            input int unsigned max_bits);
    logic [5:0] h;
    h = 6'd32 - {1'b0, prefix};
    if (h < 6'd2) begin
      h = 6'd2;
    end
    if (h > 6'(max_bits)) begin
      h = 6'(max_bits);
    end
    return h;
  endfunction

endpackage

// ===== hw/rtl/sapa_tree_mem.sv =====
module sapa_tree_mem #(
  parameter int unsigned AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  localparam int unsigned DEPTH = (1 << AW) - 1;

  logic marks [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      marks[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= marks[raddr];
  end

endmodule

// ===== hw/rtl/sapa_walker.sv =====
module sapa_walker #(
  parameter int unsigned MAX_HOST_BITS = sapa_pkg::MAX_HOST_BITS,
  parameter int unsigned AW = MAX_HOST_BITS + 1,
  parameter int unsigned HW = $clog2(MAX_HOST_BITS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              init_req,
  input  logic [HW-1:0]     host_bits,
  input  logic [31:0]       network_address,
  input  logic              in_valid,
  input  logic              mode,
  input  logic [31:0]       address,
  output logic              ready,
  input  logic              out_room,
  output logic              done,
  output sapa_pkg::result_t result,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic              mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic              mem_rdata
);

  localparam int unsigned M  = MAX_HOST_BITS;
  localparam int unsigned FW = MAX_HOST_BITS;

  sapa_pkg::walk_state_t state, state_next;

  logic [AW-1:0] idx, idx_next;
  logic [HW-1:0] lvl, lvl_next;
  logic [M-1:0]  sw_i, sw_i_next;
  logic          cur_full, cur_full_next;
  logic          mode_r, mode_r_next;
  logic [1:0]    status_r, status_r_next;
  logic [M-1:0]  host_r, host_r_next;
  logic [FW-1:0] free_total, free_total_next;

  logic [M:0]    span;
  logic [M-1:0]  top_m;
  logic [AW-1:0] top_a;
  logic [M-1:0]  host_in;
  logic [AW-1:0] leaf_in;
  logic [AW-1:0] left;
  logic [AW-1:0] pick;
  logic [AW-1:0] parent;
  logic [AW-1:0] sw_base;
  logic [AW-1:0] sw_addr;
  logic          sw_init_full;
  logic [FW:0]   free_init;

  function automatic logic [AW-1:0] sibling(input logic [AW-1:0] n);
    return n[0] ? n + AW'(1) : n - AW'(1);
  endfunction

  always_comb begin
    span      = (M + 1)'(1) << host_bits;
    top_m     = M'(span - (M + 1)'(1));
    top_a     = AW'(span - (M + 1)'(1));
    host_in   = address[M-1:0] & top_m;
    leaf_in   = top_a + AW'(host_in);
    left      = {idx[AW-2:0], 1'b1};
    pick      = mem_rdata ? left + AW'(1) : left;
    parent    = (idx - AW'(1)) >> 1;
    sw_base   = (AW'(1) << lvl) - AW'(1);
    sw_addr   = sw_base + AW'(sw_i);
    free_init = span - (FW + 1)'(3);
    // Only the three reserved leaves and the parent of the two top ones start full.
    sw_init_full = ((lvl == host_bits) &&
                    (sw_i == '0 || sw_i == top_m - M'(1) || sw_i == top_m)) ||
                   ((HW'(lvl + HW'(1)) == host_bits) && (sw_i == (top_m >> 1)));
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    lvl_next        = lvl;
    sw_i_next       = sw_i;
    cur_full_next   = cur_full;
    mode_r_next     = mode_r;
    status_r_next   = status_r;
    host_r_next     = host_r;
    free_total_next = free_total;
    ready           = 1'b0;
    done            = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = 1'b0;
    mem_raddr       = left;

    case (state)
      sapa_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sw_addr;
        mem_wdata = sw_init_full;
        if (AW'(sw_i) == sw_base) begin
          sw_i_next = '0;
          if (lvl == HW'(M)) begin
            lvl_next        = '0;
            free_total_next = FW'(free_init);
            state_next      = sapa_pkg::S_IDLE;
          end else begin
            lvl_next = lvl + HW'(1);
          end
        end else begin
          sw_i_next = sw_i + M'(1);
        end
      end
      sapa_pkg::S_IDLE: begin
        ready = 1'b1;
        if (in_valid) begin
          mode_r_next   = mode;
          status_r_next = sapa_pkg::STATUS_OK;
          if (!mode) begin
            mem_raddr  = '0;
            idx_next   = '0;
            lvl_next   = '0;
            state_next = sapa_pkg::S_ROOT;
          end else if (host_in == '0 || host_in == top_m ||
                       host_in == top_m - M'(1)) begin
            status_r_next = sapa_pkg::STATUS_IGNORED;
            state_next    = sapa_pkg::S_DONE;
          end else begin
            mem_raddr  = leaf_in;
            idx_next   = leaf_in;
            state_next = sapa_pkg::S_LEAF;
          end
        end
      end
      sapa_pkg::S_ROOT: begin
        mem_raddr = left;
        if (mem_rdata) begin
          status_r_next = sapa_pkg::STATUS_EXHAUSTED;
          state_next    = sapa_pkg::S_DONE;
        end else begin
          state_next = sapa_pkg::S_DESC;
        end
      end
      sapa_pkg::S_DESC: begin
        idx_next = pick;
        lvl_next = lvl + HW'(1);
        if (HW'(lvl + HW'(1)) == host_bits) begin
          mem_we        = 1'b1;
          mem_waddr     = pick;
          mem_wdata     = 1'b1;
          mem_raddr     = sibling(pick);
          cur_full_next = 1'b1;
          host_r_next   = M'(pick - top_a);
          state_next    = sapa_pkg::S_UP;
        end else begin
          mem_raddr = {pick[AW-2:0], 1'b1};
        end
      end
      sapa_pkg::S_LEAF: begin
        if (!mem_rdata) begin
          status_r_next = sapa_pkg::STATUS_IGNORED;
          state_next    = sapa_pkg::S_DONE;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = idx;
          mem_wdata     = 1'b0;
          mem_raddr     = sibling(idx);
          cur_full_next = 1'b0;
          state_next    = sapa_pkg::S_UP;
        end
      end
      sapa_pkg::S_UP: begin
        mem_we        = 1'b1;
        mem_waddr     = parent;
        mem_wdata     = cur_full & mem_rdata;
        mem_raddr     = sibling(parent);
        cur_full_next = cur_full & mem_rdata;
        idx_next      = parent;
        if (parent == '0) begin
          free_total_next = mode_r ? free_total + FW'(1) : free_total - FW'(1);
          state_next      = sapa_pkg::S_DONE;
        end
      end
      sapa_pkg::S_DONE: begin
        if (out_room) begin
          done       = 1'b1;
          state_next = sapa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sapa_pkg::S_IDLE;
      end
    endcase

    if (init_req) begin
      state_next = sapa_pkg::S_INIT;
      lvl_next   = '0;
      sw_i_next  = '0;
    end
  end

  always_comb begin
    result.status = status_r;
    if (!mode_r && status_r == sapa_pkg::STATUS_OK) begin
      result.granted_address = network_address | 32'(host_r);
    end else begin
      result.granted_address = '0;
    end
    if (32'(free_total) > 32'd255) begin
      result.free_count = 8'hFF;
    end else begin
      result.free_count = 8'(free_total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sapa_pkg::S_INIT;
      lvl   <= '0;
      sw_i  <= '0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      sw_i  <= sw_i_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    cur_full   <= cur_full_next;
    mode_r     <= mode_r_next;
    status_r   <= status_r_next;
    host_r     <= host_r_next;
    free_total <= free_total_next;
  end

endmodule

// ===== hw/rtl/subnet_address_pool_allocator_top.sv =====
// Subnet address pool allocator. Input channel (in_valid, in_stall, mode, address):
// one transfer is one request. mode 0 allocates the lowest free host number of the
// subnet; mode 1 releases the host number held in the low host bits of address.
// Output channel (out_valid, out_stall, granted_address, status, free_count) carries
// exactly one result for every request that no prefix write cuts short, in order.
// The configuration port writes network_address (index 0) or prefix_length (index 1);
// a prefix write rebuilds the pool for the new host width.
//
// The full marks of the host tree live in a small memory with one read and one
// write port, and the sequencer visits one tree level per cycle. With h host bits,
// an allocation reads the root, takes h steps down and h steps back up, then hands
// over to the output register; a release reads its leaf and takes h steps up. An
// unallocated release or an exhausted pool is handed over when found, a reserved
// release at once. One request is in flight at a time; the next waits for idle.
//
// After reset, and after each prefix write, a clearing pass writes every entry of
// the tree memory while in_stall stays high. A result waiting under out_stall is
// held; the next request is still taken, and it waits at its end until the output
// register is free.
module subnet_address_pool_allocator_top #(
  parameter int unsigned MAX_HOST_BITS = sapa_pkg::MAX_HOST_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] granted_address,
  output logic [1:0]  status,
  output logic [7:0]  free_count,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned AW = MAX_HOST_BITS + 1;
  localparam int unsigned HW = $clog2(MAX_HOST_BITS + 1);

  // Configuration registers. The prefix is kept only as the clamped host width.
  logic [31:0]       network_address;
  logic [HW-1:0]     host_bits;
  logic              init_req;

  logic              ready;
  logic              out_room;
  logic              done;
  sapa_pkg::result_t result;
  sapa_pkg::result_t out_data;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic              mem_rdata;

  assign init_req = cfg_write && (cfg_index == sapa_pkg::REG_PREFIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      network_address <= '0;
      host_bits       <= HW'(sapa_pkg::host_width(sapa_pkg::PREFIX_RESET, MAX_HOST_BITS));
    end else if (cfg_write) begin
      if (cfg_index == sapa_pkg::REG_NETWORK) begin
        network_address <= cfg_data;
      end else begin
        host_bits <= HW'(sapa_pkg::host_width(cfg_data[4:0], MAX_HOST_BITS));
      end
    end
  end

  // The output register frees itself in the cycle its transfer completes.
  assign out_room = !out_valid || !out_stall;
  assign in_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data <= result;
    end
  end

  assign granted_address = out_data.granted_address;
  assign status          = out_data.status;
  assign free_count      = out_data.free_count;

  sapa_walker #(
    .MAX_HOST_BITS(MAX_HOST_BITS),
    .AW(AW),
    .HW(HW)
  ) u_walker (
    .clk(clk),
    .rst(rst),
    .init_req(init_req),
    .host_bits(host_bits),
    .network_address(network_address),
    .in_valid(in_valid),
    .mode(mode),
    .address(address),
    .ready(ready),
    .out_room(out_room),
    .done(done),
    .result(result),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  sapa_tree_mem #(
    .AW(AW)
  ) u_tree_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
